FILE: rtl/core/cnms_pkg.sv
package cnms_pkg;

	// field widths
	localparam int YEAR_W    = 12;
	localparam int MONTH_W   = 4;
	localparam int MDAY_W    = 5;
	localparam int HOUR_W    = 5;
	localparam int MINUTE_W  = 6;
	localparam int SECOND_W  = 6;
	localparam int WDAY_W    = 3;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 60;

	localparam logic [CFG_IDX_W-1:0] REG_SECOND_MASK  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MINUTE_MASK  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOUR_MASK    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MONTH_MASK   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MDAY_MASK    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEEKDAY_MASK = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DAY_SELECT   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_YEAR  = 4'd7;

	// calendar
	localparam int LAST_YEAR_DEF = 2037;
	localparam logic [YEAR_W-1:0]  FIRST_YEAR    = 12'd1970;
	localparam logic [WDAY_W-1:0]  FIRST_JAN1_WD = 3'd4;   // jan 1 1970 is a thursday
	localparam logic [6:0]         FIRST_MOD100  = 7'd70;
	localparam logic [8:0]         FIRST_MOD400  = 9'd370;
	localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd11;

	function automatic logic [MDAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [MDAY_W-1:0] d;
		case (m)
			4'd1: d = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

	// weekday shift from the first of a month to the first of the next
	function automatic logic [WDAY_W-1:0] month_shift(input logic [MDAY_W-1:0] dim);
		logic [WDAY_W-1:0] s;
		case (dim)
			5'd29: s = 3'd1;
			5'd30: s = 3'd2;
			5'd31: s = 3'd3;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

	function automatic logic [WDAY_W-1:0] add_mod7(input logic [WDAY_W-1:0] a,
		input logic [WDAY_W-1:0] b);
		logic [WDAY_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 4'd7)
			s = s - 4'd7;
		return s[WDAY_W-1:0];
	endfunction

	// lowest set bit at or above from: {hit, index}
	function automatic logic [6:0] first_set(input logic [63:0] v, input logic [6:0] from);
		logic [63:0] masked;
		logic [6:0]  r;
		masked = v & ({64{1'b1}} << from);
		r = 7'd0;
		for (int i = 63; i >= 0; i--) begin
			if (masked[i])
				r = {1'b1, 6'(i)};
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/cron_next_match_search_top.sv
// next cron match search: a transaction on the input channel carries a broken-down
// utc time; the block answers with one transaction holding the earliest later time
// whose second, minute, hour and month are enabled in their masks, whose date passes
// the day rule (day-of-month list, weekday list, their union, or every day) and whose
// year is at most LAST_YEAR (and equal to target_year when that is nonzero). found is
// 0 with all other fields zero when nothing matches. one shared priority encoder
// finds the first enabled second, minute and hour and the first ones after the current
// time fields; then a small sequencer steps the year from 1970 up to the start year
// (for the jan 1 weekday and leap tracking), walks months and days, and writes the
// result. the block takes one search at a time; the next may start while the last
// result waits on out_ready. configuration writes are meant for idle periods only.
module cron_next_match_search_top #(
	parameter int LAST_YEAR = cnms_pkg::LAST_YEAR_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [cnms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cnms_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [cnms_pkg::YEAR_W-1:0]        now_year,
	input  logic [cnms_pkg::MONTH_W-1:0]       now_month,
	input  logic [cnms_pkg::MDAY_W-1:0]        now_mday,
	input  logic [cnms_pkg::HOUR_W-1:0]        now_hour,
	input  logic [cnms_pkg::MINUTE_W-1:0]      now_minute,
	input  logic [cnms_pkg::SECOND_W-1:0]      now_second,
	// output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic [cnms_pkg::YEAR_W-1:0]        next_year,
	output logic [cnms_pkg::MONTH_W-1:0]       next_month,
	output logic [cnms_pkg::MDAY_W-1:0]        next_mday,
	output logic [cnms_pkg::HOUR_W-1:0]        next_hour,
	output logic [cnms_pkg::MINUTE_W-1:0]      next_minute,
	output logic [cnms_pkg::SECOND_W-1:0]      next_second
);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FIND   = 3'd1;  // shared encoder setup
	localparam logic [2:0] ST_YINIT  = 3'd2;  // step year up to the start year
	localparam logic [2:0] ST_MONTH  = 3'd3;
	localparam logic [2:0] ST_DAY    = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	// encoder jobs, one per setup cycle
	localparam logic [2:0] ENC_SEC_FIRST  = 3'd0;
	localparam logic [2:0] ENC_MIN_FIRST  = 3'd1;
	localparam logic [2:0] ENC_HOUR_FIRST = 3'd2;
	localparam logic [2:0] ENC_SEC_AFTER  = 3'd3;
	localparam logic [2:0] ENC_MIN_AFTER  = 3'd4;
	localparam logic [2:0] ENC_HOUR_AFTER = 3'd5;

	localparam logic [cnms_pkg::YEAR_W-1:0] LAST_Y = cnms_pkg::YEAR_W'(LAST_YEAR);

	// configuration registers
	logic [59:0] second_mask_q, minute_mask_q;
	logic [23:0] hour_mask_q;
	logic [11:0] month_mask_q;
	logic [30:0] mday_mask_q;
	logic [6:0]  weekday_mask_q;
	logic [1:0]  day_select_q;
	logic [cnms_pkg::YEAR_W-1:0] target_year_q;

	// control
	logic [2:0] state_q;
	logic [2:0] enc_step_q;
	logic       out_valid_q;

	// latched request
	logic [cnms_pkg::YEAR_W-1:0]   now_year_q;
	logic [cnms_pkg::MONTH_W-1:0]  now_month_q;
	logic [cnms_pkg::MDAY_W-1:0]   now_mday_q;
	logic [cnms_pkg::HOUR_W-1:0]   now_hour_q;
	logic [cnms_pkg::MINUTE_W-1:0] now_minute_q;
	logic [cnms_pkg::SECOND_W-1:0] now_second_q;

	// encoder results
	logic [5:0] fs_q, fm_q, fh_q, ts_q, tm_q, th_q;
	logic       fs_hit_q, fm_hit_q, fh_hit_q, ts_hit_q, tm_hit_q, th_hit_q;

	// walk position
	logic [cnms_pkg::YEAR_W-1:0]  y_q, y_start_q, y_end_q;
	logic [cnms_pkg::MONTH_W-1:0] m_q;
	logic [cnms_pkg::MDAY_W-1:0]  d_q;
	logic [cnms_pkg::WDAY_W-1:0]  wd_m1_q;   // weekday of the 1st of month m_q
	logic [cnms_pkg::WDAY_W-1:0]  wd_d_q;    // weekday of day d_q
	logic [6:0]                   mod100_q;
	logic [8:0]                   mod400_q;

	// pending result
	logic                          res_found_q;
	logic [cnms_pkg::YEAR_W-1:0]   res_year_q;
	logic [cnms_pkg::MONTH_W-1:0]  res_month_q;
	logic [cnms_pkg::MDAY_W-1:0]   res_mday_q;
	logic [cnms_pkg::HOUR_W-1:0]   res_hour_q;
	logic [cnms_pkg::MINUTE_W-1:0] res_minute_q;
	logic [cnms_pkg::SECOND_W-1:0] res_second_q;

	// output register
	logic                          found_q;
	logic [cnms_pkg::YEAR_W-1:0]   next_year_q;
	logic [cnms_pkg::MONTH_W-1:0]  next_month_q;
	logic [cnms_pkg::MDAY_W-1:0]   next_mday_q;
	logic [cnms_pkg::HOUR_W-1:0]   next_hour_q;
	logic [cnms_pkg::MINUTE_W-1:0] next_minute_q;
	logic [cnms_pkg::SECOND_W-1:0] next_second_q;

	// ---------------------------------------------------------------- combinational
	logic        accept;
	logic [63:0] enc_vec;
	logic [6:0]  enc_from;
	logic [6:0]  enc_res;

	logic                         find_done, setup_fail;
	logic [cnms_pkg::YEAR_W-1:0]  ny_clamp, y0, y1;
	logic                         tgt_set, tgt_bad;

	logic                         leap;
	logic [cnms_pkg::MDAY_W-1:0]  dim;
	logic [cnms_pkg::WDAY_W-1:0]  wd_m1_nx;
	logic [6:0]                   mod100_nx;
	logic [8:0]                   mod400_nx;

	logic                         ny_eq, month_ok, before_now, start_date;
	logic                         dom_bit, wd_bit, day_ok;
	logic                         day_hit, adv_month, search_end, yinit_done;
	logic [23:0]                  hm_sh;
	logic [59:0]                  mm_sh;
	logic [11:0]                  mo_sh;
	logic                         cur_h_ok, cur_m_ok;
	logic                         ta_ok;
	logic [cnms_pkg::HOUR_W-1:0]   ta_h;
	logic [cnms_pkg::MINUTE_W-1:0] ta_m;
	logic [cnms_pkg::SECOND_W-1:0] ta_s;
	logic                         out_load;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// shared priority encoder input select
	always_comb begin
		enc_vec  = 64'd0;
		enc_from = 7'd0;
		case (enc_step_q)
			ENC_SEC_FIRST:  enc_vec = {4'd0, second_mask_q};
			ENC_MIN_FIRST:  enc_vec = {4'd0, minute_mask_q};
			ENC_HOUR_FIRST: enc_vec = {40'd0, hour_mask_q};
			ENC_SEC_AFTER: begin
				enc_vec  = {4'd0, second_mask_q};
				enc_from = {1'b0, now_second_q} + 7'd1;
			end
			ENC_MIN_AFTER: begin
				enc_vec  = {4'd0, minute_mask_q};
				enc_from = {1'b0, now_minute_q} + 7'd1;
			end
			ENC_HOUR_AFTER: begin
				enc_vec  = {40'd0, hour_mask_q};
				enc_from = {2'd0, now_hour_q} + 7'd1;
			end
			default: begin
				enc_vec  = 64'd0;
				enc_from = 7'd0;
			end
		endcase
	end

	assign enc_res = cnms_pkg::first_set(enc_vec, enc_from);

	// year range of the search
	assign ny_clamp   = (now_year_q < cnms_pkg::FIRST_YEAR) ? cnms_pkg::FIRST_YEAR : now_year_q;
	assign tgt_set    = (target_year_q != '0);
	assign tgt_bad    = tgt_set && (target_year_q < ny_clamp);
	assign y0         = tgt_set ? target_year_q : ny_clamp;
	assign y1         = (tgt_set && (target_year_q < LAST_Y)) ? target_year_q : LAST_Y;
	assign find_done  = (state_q == ST_FIND) && (enc_step_q == ENC_HOUR_AFTER);
	assign setup_fail = (month_mask_q == '0) || !fs_hit_q || !fm_hit_q || !fh_hit_q
		|| tgt_bad || (y0 > y1);

	// calendar tracking
	assign leap      = (y_q[1:0] == 2'b00) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
	assign dim       = cnms_pkg::days_in_month(m_q, leap);
	assign wd_m1_nx  = cnms_pkg::add_mod7(wd_m1_q, cnms_pkg::month_shift(dim));
	assign mod100_nx = (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
	assign mod400_nx = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
	assign yinit_done = (state_q == ST_YINIT) && (y_q == y_start_q);

	// month and day qualification
	assign mo_sh      = month_mask_q >> m_q;
	assign ny_eq      = (y_q == now_year_q);
	assign month_ok   = mo_sh[0] && !(ny_eq && (m_q < now_month_q));
	assign before_now = ny_eq && (m_q == now_month_q) && (d_q < now_mday_q);
	assign start_date = ny_eq && (m_q == now_month_q) && (d_q == now_mday_q);
	assign dom_bit    = day_select_q[0] && mday_mask_q[d_q - 5'd1];
	assign wd_bit     = day_select_q[1] && weekday_mask_q[wd_d_q];
	assign day_ok     = (day_select_q == 2'b00) || dom_bit || wd_bit;

	// first enabled time after now, on the starting date
	assign hm_sh    = hour_mask_q >> now_hour_q;
	assign mm_sh    = minute_mask_q >> now_minute_q;
	assign cur_h_ok = (now_hour_q < 5'd24) && hm_sh[0];
	assign cur_m_ok = (now_minute_q < 6'd60) && mm_sh[0];

	always_comb begin
		ta_ok = 1'b0;
		ta_h  = '0;
		ta_m  = '0;
		ta_s  = '0;
		if (cur_h_ok && cur_m_ok && ts_hit_q) begin
			ta_ok = 1'b1;
			ta_h  = now_hour_q;
			ta_m  = now_minute_q;
			ta_s  = ts_q;
		end else if (cur_h_ok && tm_hit_q) begin
			ta_ok = 1'b1;
			ta_h  = now_hour_q;
			ta_m  = tm_q;
			ta_s  = fs_q;
		end else if (th_hit_q) begin
			ta_ok = 1'b1;
			ta_h  = th_q[cnms_pkg::HOUR_W-1:0];
			ta_m  = fm_q;
			ta_s  = fs_q;
		end
	end

	assign day_hit    = (state_q == ST_DAY) && !before_now && day_ok && (!start_date || ta_ok);
	assign adv_month  = ((state_q == ST_MONTH) && !month_ok)
		|| ((state_q == ST_DAY) && !day_hit && (d_q == dim));
	assign search_end = adv_month && (m_q == cnms_pkg::MONTH_DEC) && (y_q == y_end_q);
	assign out_load   = (state_q == ST_RESULT) && (!out_valid_q || out_ready);

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			enc_step_q     <= ENC_SEC_FIRST;
			out_valid_q    <= 1'b0;
			second_mask_q  <= {60{1'b1}};
			minute_mask_q  <= {60{1'b1}};
			hour_mask_q    <= {24{1'b1}};
			month_mask_q   <= {12{1'b1}};
			mday_mask_q    <= '0;
			weekday_mask_q <= '0;
			day_select_q   <= '0;
			target_year_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cnms_pkg::REG_SECOND_MASK:  second_mask_q  <= cfg_data[59:0];
					cnms_pkg::REG_MINUTE_MASK:  minute_mask_q  <= cfg_data[59:0];
					cnms_pkg::REG_HOUR_MASK:    hour_mask_q    <= cfg_data[23:0];
					cnms_pkg::REG_MONTH_MASK:   month_mask_q   <= cfg_data[11:0];
					cnms_pkg::REG_MDAY_MASK:    mday_mask_q    <= cfg_data[30:0];
					cnms_pkg::REG_WEEKDAY_MASK: weekday_mask_q <= cfg_data[6:0];
					cnms_pkg::REG_DAY_SELECT:   day_select_q   <= cfg_data[1:0];
					cnms_pkg::REG_TARGET_YEAR:  target_year_q  <= cfg_data[11:0];
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_FIND;
						enc_step_q <= ENC_SEC_FIRST;
					end
				end
				ST_FIND: begin
					enc_step_q <= enc_step_q + 3'd1;
					if (find_done)
						state_q <= setup_fail ? ST_RESULT : ST_YINIT;
				end
				ST_YINIT: begin
					if (yinit_done)
						state_q <= ST_MONTH;
				end
				ST_MONTH: begin
					if (month_ok)
						state_q <= ST_DAY;
					else if (search_end)
						state_q <= ST_RESULT;
				end
				ST_DAY: begin
					if (day_hit || search_end)
						state_q <= ST_RESULT;
					else if (adv_month)
						state_q <= ST_MONTH;
				end
				ST_RESULT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			now_year_q   <= now_year;
			now_month_q  <= now_month;
			now_mday_q   <= now_mday;
			now_hour_q   <= now_hour;
			now_minute_q <= now_minute;
			now_second_q <= now_second;
		end

		if (state_q == ST_FIND) begin
			case (enc_step_q)
				ENC_SEC_FIRST:  {fs_hit_q, fs_q} <= enc_res;
				ENC_MIN_FIRST:  {fm_hit_q, fm_q} <= enc_res;
				ENC_HOUR_FIRST: {fh_hit_q, fh_q} <= enc_res;
				ENC_SEC_AFTER:  {ts_hit_q, ts_q} <= enc_res;
				ENC_MIN_AFTER:  {tm_hit_q, tm_q} <= enc_res;
				ENC_HOUR_AFTER: {th_hit_q, th_q} <= enc_res;
				default: ;
			endcase
		end

		if (find_done) begin
			y_q       <= cnms_pkg::FIRST_YEAR;
			wd_m1_q   <= cnms_pkg::FIRST_JAN1_WD;
			mod100_q  <= cnms_pkg::FIRST_MOD100;
			mod400_q  <= cnms_pkg::FIRST_MOD400;
			y_start_q <= y0;
			y_end_q   <= y1;
		end

		// step jan 1 weekday year by year
		if (state_q == ST_YINIT) begin
			if (yinit_done) begin
				m_q <= '0;
			end else begin
				wd_m1_q  <= cnms_pkg::add_mod7(wd_m1_q, leap ? 3'd2 : 3'd1);
				y_q      <= y_q + 12'd1;
				mod100_q <= mod100_nx;
				mod400_q <= mod400_nx;
			end
		end

		if ((state_q == ST_MONTH) && month_ok) begin
			d_q    <= 5'd1;
			wd_d_q <= wd_m1_q;
		end

		if ((state_q == ST_DAY) && !day_hit && (d_q != dim)) begin
			d_q    <= d_q + 5'd1;
			wd_d_q <= cnms_pkg::add_mod7(wd_d_q, 3'd1);
		end

		if (adv_month) begin
			wd_m1_q <= wd_m1_nx;
			if (m_q == cnms_pkg::MONTH_DEC) begin
				m_q      <= '0;
				y_q      <= y_q + 12'd1;
				mod100_q <= mod100_nx;
				mod400_q <= mod400_nx;
			end else begin
				m_q <= m_q + 4'd1;
			end
		end

		// pending result: zeros unless a date hit
		if ((find_done && setup_fail) || search_end || day_hit) begin
			res_found_q  <= day_hit;
			res_year_q   <= day_hit ? y_q : '0;
			res_month_q  <= day_hit ? m_q : '0;
			res_mday_q   <= day_hit ? d_q : '0;
			res_hour_q   <= !day_hit ? '0 : start_date ? ta_h : fh_q[cnms_pkg::HOUR_W-1:0];
			res_minute_q <= !day_hit ? '0 : start_date ? ta_m : fm_q;
			res_second_q <= !day_hit ? '0 : start_date ? ta_s : fs_q;
		end

		if (out_load) begin
			found_q       <= res_found_q;
			next_year_q   <= res_year_q;
			next_month_q  <= res_month_q;
			next_mday_q   <= res_mday_q;
			next_hour_q   <= res_hour_q;
			next_minute_q <= res_minute_q;
			next_second_q <= res_second_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign next_year   = next_year_q;
	assign next_month  = next_month_q;
	assign next_mday   = next_mday_q;
	assign next_hour   = next_hour_q;
	assign next_minute = next_minute_q;
	assign next_second = next_second_q;

	// ---------------------------------------------------------------- checks
	// a miss carries an all-zero time
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (next_year == '0 && next_month == '0 && next_mday == '0
			&& next_hour == '0 && next_minute == '0 && next_second == '0))
		else $error("miss transaction with nonzero time");

	// a hit lands on enabled second, minute, hour and month
	a_hit_masks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (next_month < 4'd12 && next_hour < 5'd24
			&& next_minute < 6'd60 && next_second < 6'd60
			&& month_mask_q[next_month] && hour_mask_q[next_hour]
			&& minute_mask_q[next_minute] && second_mask_q[next_second]))
		else $error("hit on a disabled time field");

	// the day walk stays inside the current month
	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DAY) |-> (d_q >= 5'd1 && d_q <= dim && m_q < 4'd12))
		else $error("day walk out of month");

	// the walk never passes the end year
	a_year_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MONTH || state_q == ST_DAY) |-> (y_q <= y_end_q && y_q >= y_start_q))
		else $error("walk outside year range");

	// an accepted transaction keeps the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (!in_ready && state_q == ST_FIND))
		else $error("not busy after accept");

endmodule

FILE: sim/testbench.sv
module testbench;
	import cnms_pkg::*;

	localparam int LAST_YEAR = LAST_YEAR_DEF;
	localparam int unsigned EPOCH_YEAR = 1970;
	// indexes from here up map to no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd8;

	// broken-down time as carried on the ports
	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [MDAY_W-1:0]   mday;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
	} stamp_t;

	typedef struct packed {
		logic   found;
		stamp_t at;
	} match_t;

	// mirror of the schedule registers, predicted matches in arrival order
	class next_match_board;
		bit [59:0] sec_mask;
		bit [59:0] min_mask;
		bit [23:0] hour_mask;
		bit [11:0] month_mask;
		bit [30:0] mday_mask;
		bit [6:0]  wday_mask;
		bit [1:0]  day_sel;
		bit [11:0] target;
		match_t    awaited_matches[$];
		int        errors;

		function new();
			sec_mask   = '1;
			min_mask   = '1;
			hour_mask  = '1;
			month_mask = '1;
			mday_mask  = '0;
			wday_mask  = '0;
			day_sel    = '0;
			target     = '0;
			errors     = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_SECOND_MASK:  sec_mask   = v[59:0];
				REG_MINUTE_MASK:  min_mask   = v[59:0];
				REG_HOUR_MASK:    hour_mask  = v[23:0];
				REG_MONTH_MASK:   month_mask = v[11:0];
				REG_MDAY_MASK:    mday_mask  = v[30:0];
				REG_WEEKDAY_MASK: wday_mask  = v[6:0];
				REG_DAY_SELECT:   day_sel    = v[1:0];
				REG_TARGET_YEAR:  target     = v[11:0];
				default: ;
			endcase
		endfunction

		function int unsigned first_from(bit [63:0] v, int unsigned from, int unsigned w);
			for (int unsigned i = from; i < w; i++)
				if (v[i])
					return i;
			return w;
		endfunction

		// earliest scheduled time strictly after q, or all zeros
		function match_t predict_next_match(stamp_t q);
			match_t r;
			int unsigned ny, y0, y1, y, m, d, dim, yy, ofs, wd, h, mi, s, t;
			bit hit;
			r = '0;
			ny = q.year;
			if (sec_mask == 0 || min_mask == 0 || hour_mask == 0 || month_mask == 0)
				return r;
			y0 = (ny < EPOCH_YEAR) ? EPOCH_YEAR : ny;
			y1 = LAST_YEAR;
			if (target != 0) begin
				if (target < y0)
					return r;
				y0 = target;
				if (y1 > target)
					y1 = target;
			end
			for (y = y0; y <= y1; y++) begin
				for (m = 0; m < 12; m++) begin
					if (!month_mask[m] || (y == ny && m < q.month))
						continue;
					case (m)
						1: dim = ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
						3, 5, 8, 10: dim = 30;
						default: dim = 31;
					endcase
					for (d = 1; d <= dim; d++) begin
						if (y == ny && m == q.month && d < q.mday)
							continue;
						if (day_sel != 0) begin
							// weekday by month offset table, year taken back for jan and feb
							yy = (m < 2) ? y - 1 : y;
							case (m)
								0, 4: ofs = 0;
								7: ofs = 1;
								2, 10: ofs = 2;
								1, 5: ofs = 3;
								8, 11: ofs = 4;
								3, 6: ofs = 5;
								default: ofs = 6;
							endcase
							wd = (yy + yy / 4 - yy / 100 + yy / 400 + ofs + d) % 7;
							hit = (day_sel[0] && mday_mask[d - 1]) || (day_sel[1] && wday_mask[wd]);
							if (!hit)
								continue;
						end
						h  = first_from(hour_mask, 0, 24);
						mi = first_from(min_mask, 0, 60);
						s  = first_from(sec_mask, 0, 60);
						if (y == ny && m == q.month && d == q.mday) begin
							hit = 1'b0;
							if (q.hour < 24 && hour_mask[q.hour]) begin
								t = first_from(sec_mask, q.second + 1, 60);
								if (q.minute < 60 && min_mask[q.minute] && t < 60) begin
									h = q.hour;
									mi = q.minute;
									s = t;
									hit = 1'b1;
								end else begin
									t = first_from(min_mask, q.minute + 1, 60);
									if (t < 60) begin
										h = q.hour;
										mi = t;
										hit = 1'b1;
									end
								end
							end
							if (!hit) begin
								t = first_from(hour_mask, q.hour + 1, 24);
								if (t < 24) begin
									h = t;
									hit = 1'b1;
								end
							end
							if (!hit)
								continue;
						end
						r.found = 1'b1;
						r.at = '{YEAR_W'(y), MONTH_W'(m), MDAY_W'(d), HOUR_W'(h),
							MINUTE_W'(mi), SECOND_W'(s)};
						return r;
					end
				end
			end
			return r;
		endfunction

		function void note_query(stamp_t q);
			awaited_matches.push_back(predict_next_match(q));
		endfunction

		function string show(match_t v);
			return $sformatf("found=%0d %0d/%0d/%0d %0d:%0d:%0d", v.found, v.at.year,
				v.at.month, v.at.mday, v.at.hour, v.at.minute, v.at.second);
		endfunction

		function void check_answer(match_t got);
			match_t want;
			if (awaited_matches.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transaction: %s", show(got));
				return;
			end
			want = awaited_matches.pop_front();
			if (got.found !== want.found || got.at.year !== want.at.year
				|| got.at.month !== want.at.month || got.at.mday !== want.at.mday
				|| got.at.hour !== want.at.hour || got.at.minute !== want.at.minute
				|| got.at.second !== want.at.second) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %s, got %s", show(want), show(got));
			end
		endfunction
	endclass

	// clock, reset and block ports, all known from time zero
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [YEAR_W-1:0]     now_year = '0;
	logic [MONTH_W-1:0]    now_month = '0;
	logic [MDAY_W-1:0]     now_mday = '0;
	logic [HOUR_W-1:0]     now_hour = '0;
	logic [MINUTE_W-1:0]   now_minute = '0;
	logic [SECOND_W-1:0]   now_second = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  found;
	logic [YEAR_W-1:0]     next_year;
	logic [MONTH_W-1:0]    next_month;
	logic [MDAY_W-1:0]     next_mday;
	logic [HOUR_W-1:0]     next_hour;
	logic [MINUTE_W-1:0]   next_minute;
	logic [SECOND_W-1:0]   next_second;

	// when set, neither side idles
	bit steady = 1'b0;

	next_match_board board;

	cron_next_match_search_top #(.LAST_YEAR(LAST_YEAR)) i_dut (.*);

	always #5 clk = ~clk;

	// hard stop in case the block hangs; far beyond the slowest legal run
	initial begin
		#200_000_000;
		$display("testbench failed");
		$finish;
	end

	// result side: sample on the edge, stall at random a quarter of the time
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_answer({found, next_year, next_month, next_mday, next_hour,
				next_minute, next_second});
		out_ready <= steady || $urandom_range(99) >= 25;
	end

	function automatic stamp_t stamp(int y, int mo, int d, int h, int mi, int s);
		return '{YEAR_W'(y), MONTH_W'(mo), MDAY_W'(d), HOUR_W'(h), MINUTE_W'(mi),
			SECOND_W'(s)};
	endfunction

	// register write, mirrored into the predictor once the block has taken it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, v);
	endtask

	// one query transaction; valid stays up afterwards so a following call
	// with no gap goes back to back
	task automatic send_query(stamp_t q);
		int gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(99) < 25)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{now_year, now_month, now_mday, now_hour, now_minute, now_second} <= q;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_query(q);
	endtask

	// drop valid and wait until every predicted match has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (board.awaited_matches.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// all ones, one or two bits, or a dense random pattern
	function automatic logic [63:0] rand_mask(int w);
		logic [63:0] m;
		case ($urandom_range(7))
			0: m = '1;
			1: m = 64'd1 << $urandom_range(w - 1);
			2: m = (64'd1 << $urandom_range(w - 1)) | (64'd1 << $urandom_range(w - 1));
			default: m = {$urandom, $urandom};
		endcase
		return m & ((64'd1 << w) - 64'd1);
	endfunction

	task automatic random_schedule();
		logic [CFG_DATA_W-1:0] ty;
		write_reg(REG_SECOND_MASK, rand_mask(60));
		write_reg(REG_MINUTE_MASK, rand_mask(60));
		write_reg(REG_HOUR_MASK, rand_mask(24));
		write_reg(REG_MONTH_MASK, rand_mask(12));
		write_reg(REG_MDAY_MASK, rand_mask(31));
		write_reg(REG_WEEKDAY_MASK, rand_mask(7));
		write_reg(REG_DAY_SELECT, $urandom_range(3));
		case ($urandom_range(9))
			0: ty = $urandom_range(4095);
			1, 2, 3: ty = $urandom_range(LAST_YEAR, 2020);
			default: ty = '0;
		endcase
		write_reg(REG_TARGET_YEAR, ty);
	endtask

	// mostly in-range fields; the year is chosen so a search stays short
	function automatic stamp_t random_query();
		stamp_t q;
		logic dense;
		// dense: some date in every enabled month passes, so a match turns up
		// within about a year whatever the start
		dense = board.sec_mask != 0 && board.min_mask != 0 && board.hour_mask != 0
			&& board.month_mask != 0 && (board.day_sel == 0
			|| (board.day_sel[1] && board.wday_mask != 0)
			|| (board.day_sel[0] && board.mday_mask[27:0] != 0));
		if (board.target == 0 && !dense)
			q.year = ($urandom_range(9) == 0) ? $urandom_range(4095, 2038)
				: $urandom_range(2099, 2033);
		else if (board.target != 0 && $urandom_range(3) != 0)
			q.year = board.target - YEAR_W'($urandom_range(2));
		else if ($urandom_range(19) == 0)
			q.year = $urandom_range(4095);
		else
			q.year = $urandom_range(2099, 1970);
		q.month  = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(11);
		q.mday   = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(31, 1);
		q.hour   = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(23);
		q.minute = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(59);
		q.second = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(59);
		return q;
	endfunction

	logic [CFG_IDX_W-1:0] time_regs[4] = '{REG_SECOND_MASK, REG_MINUTE_MASK,
		REG_HOUR_MASK, REG_MONTH_MASK};

	initial begin
		board = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset schedule: every second of every day
		send_query(stamp(2000, 1, 28, 23, 59, 59));    // century leap day
		send_query(stamp(2023, 1, 28, 23, 59, 59));    // plain year, into march
		send_query(stamp(LAST_YEAR, 11, 31, 23, 59, 59)); // nothing left before the end
		send_query(stamp(LAST_YEAR + 1, 0, 1, 0, 0, 0)); // start past the last year
		send_query(stamp(0, 0, 0, 0, 0, 0));           // start before the epoch
		send_query(stamp(4095, 15, 31, 31, 63, 63));   // every field at its top
		send_query(stamp(1999, 15, 31, 31, 63, 63));   // month past december
		send_query(stamp(2010, 5, 30, 24, 0, 0));      // hour past the day
		send_query(stamp(2010, 3, 0, 0, 0, 0));        // day zero of the month
		drain();

		// writes to unmapped indexes must leave the schedule alone
		for (int k = 0; k < 8; k++)
			write_reg(REG_SPARE_FIRST + CFG_IDX_W'(k), '0);
		send_query(stamp(2015, 6, 15, 12, 30, 30));
		drain();

		// only 23:00:59 on december 31
		write_reg(REG_SECOND_MASK, 60'd1 << 59);
		write_reg(REG_MINUTE_MASK, 60'd1);
		write_reg(REG_HOUR_MASK, 60'd1 << 23);
		write_reg(REG_MONTH_MASK, 60'd1 << 11);
		write_reg(REG_MDAY_MASK, 60'd1 << 30);
		write_reg(REG_DAY_SELECT, 60'd1);
		send_query(stamp(2020, 11, 31, 23, 0, 58));
		send_query(stamp(2020, 11, 31, 23, 0, 59));
		send_query(stamp(LAST_YEAR, 11, 31, 23, 0, 59));
		drain();

		// midnight on sundays, then sundays or the first of the month
		write_reg(REG_SECOND_MASK, 60'd1);
		write_reg(REG_HOUR_MASK, 60'd1);
		write_reg(REG_MONTH_MASK, '1);
		write_reg(REG_WEEKDAY_MASK, 60'd1);
		write_reg(REG_DAY_SELECT, 60'd2);
		send_query(stamp(2024, 0, 1, 0, 0, 0));
		drain();
		write_reg(REG_MDAY_MASK, 60'd1);
		write_reg(REG_DAY_SELECT, 60'd3);
		send_query(stamp(2024, 0, 28, 0, 0, 0));
		drain();

		// day-of-month list selected but empty: no date ever passes
		write_reg(REG_MDAY_MASK, '0);
		write_reg(REG_DAY_SELECT, 60'd1);
		send_query(stamp(1970, 0, 1, 0, 0, 0));        // the longest walk there is
		send_query(stamp(2036, 6, 4, 0, 0, 0));
		drain();

		// target year: reachable, behind now, before the epoch, far ahead
		write_reg(REG_DAY_SELECT, '0);
		write_reg(REG_TARGET_YEAR, 60'd2024);
		send_query(stamp(2020, 5, 15, 12, 0, 0));
		send_query(stamp(2030, 5, 15, 12, 0, 0));
		drain();
		write_reg(REG_TARGET_YEAR, 60'd1969);
		send_query(stamp(1960, 0, 1, 0, 0, 0));
		drain();
		write_reg(REG_TARGET_YEAR, 60'hFFF);
		send_query(stamp(2000, 0, 1, 0, 0, 0));
		drain();
		write_reg(REG_TARGET_YEAR, '0);

		// each time or month mask empty in turn
		for (int k = 0; k < 4; k++) begin
			write_reg(time_regs[k], '0);
			send_query(stamp(2001, 2, 3, 4, 5, 6));
			drain();
			write_reg(time_regs[k], '1);
		end

		// random schedules, one quiet stretch with no idling on either side
		for (int p = 0; p < 12; p++) begin
			steady = (p == 6);
			random_schedule();
			for (int i = 0; i < 100; i++)
				send_query(random_query());
			drain();
		end
		steady = 1'b0;

		// catch any stray result transaction
		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.awaited_matches.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
